// ----- hw/rtl/cip_pkg.sv -----
`default_nettype none

package cip_pkg;

    localparam int PRESS_W = 12;
    localparam int PT_COUNT = 4;
    localparam int CFG_IDX_W = 4;
    localparam int PROD_W = 2 * PRESS_W;
    localparam int DIV_BITS_PER_STAGE = 2;
    localparam int DIV_STAGES = PRESS_W / DIV_BITS_PER_STAGE;
    localparam int SUM_W = PRESS_W + 2;

    localparam logic [PRESS_W-1:0] MIN_PRELOAD_LIMIT = 12'd0;
    localparam logic [PRESS_W-1:0] MAX_PRELOAD_LIMIT = 12'd400;
    localparam logic [PRESS_W-1:0] MIN_AFTERLOAD_LIMIT = 12'd0;
    localparam logic [PRESS_W-1:0] MAX_AFTERLOAD_LIMIT = 12'd2500;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_X_BASE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_Y_BASE = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END = 4'd8;

    localparam logic [PRESS_W-1:0] RESET_X0 = 12'd20;
    localparam logic [PRESS_W-1:0] RESET_X1 = 12'd80;
    localparam logic [PRESS_W-1:0] RESET_X2 = 12'd150;
    localparam logic [PRESS_W-1:0] RESET_X3 = 12'd250;
    localparam logic [PRESS_W-1:0] RESET_Y0 = 12'd600;
    localparam logic [PRESS_W-1:0] RESET_Y1 = 12'd1000;
    localparam logic [PRESS_W-1:0] RESET_Y2 = 12'd1200;
    localparam logic [PRESS_W-1:0] RESET_Y3 = 12'd1300;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_INVALID  = 2'd1,
        ST_SATURATE = 2'd2
    } status_t;

    typedef struct packed {
        logic [PT_COUNT-1:0][PRESS_W-1:0] x;
        logic [PT_COUNT-1:0][PRESS_W-1:0] y;
    } curve_t;

    // word carried down the pipeline; later stages fill in the arithmetic fields
    typedef struct packed {
        logic               interp;
        logic [PRESS_W-1:0] base;
        status_t            status;
        logic               neg;
        logic [PRESS_W-1:0] dx;
        logic [PRESS_W-1:0] span;
        logic [PRESS_W-1:0] dmag;
        logic [PRESS_W-1:0] rem;
        logic [PRESS_W-1:0] num;
        logic [PRESS_W-1:0] quo;
    } lane_t;

endpackage

`default_nettype wire

// ----- hw/rtl/cip_if.sv -----
`default_nettype none

interface cip_sample_if;
    logic                        valid;
    logic                        ready;
    logic [cip_pkg::PRESS_W-1:0] inlet_pressure;

    modport source (output valid, output inlet_pressure, input ready);
    modport sink (input valid, input inlet_pressure, output ready);
endinterface

interface cip_result_if;
    logic                        valid;
    logic                        ready;
    logic [cip_pkg::PRESS_W-1:0] target_pressure;
    logic [1:0]                  status;

    modport source (output valid, output target_pressure, output status, input ready);
    modport sink (input valid, input target_pressure, input status, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cip_select.sv -----
`default_nettype none

module cip_select (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cip_pkg::curve_t             curve,
    input  wire logic                        up_valid,
    output logic                             up_ready,
    input  wire logic [cip_pkg::PRESS_W-1:0] up_pressure,
    output logic                             dn_valid,
    input  wire logic                        dn_ready,
    output cip_pkg::lane_t                   dn_data
);

    logic           valid_reg;
    cip_pkg::lane_t data_reg;
    cip_pkg::lane_t data_next;

    logic [cip_pkg::PRESS_W-1:0] xa;
    logic [cip_pkg::PRESS_W-1:0] xb;
    logic [cip_pkg::PRESS_W-1:0] ya;
    logic [cip_pkg::PRESS_W-1:0] yb;
    logic [cip_pkg::PRESS_W:0]   x3_plus1;

    assign up_ready = ~valid_reg | dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
    assign x3_plus1 = {1'b0, curve.x[3]} + 13'd1;

    // first segment whose right end is at or above the sample
    always_comb
    begin
        if (up_pressure <= curve.x[1])
        begin
            xa = curve.x[0];
            xb = curve.x[1];
            ya = curve.y[0];
            yb = curve.y[1];
        end
        else if (up_pressure <= curve.x[2])
        begin
            xa = curve.x[1];
            xb = curve.x[2];
            ya = curve.y[1];
            yb = curve.y[2];
        end
        else
        begin
            xa = curve.x[2];
            xb = curve.x[3];
            ya = curve.y[2];
            yb = curve.y[3];
        end
    end

    always_comb
    begin
        data_next        = '0;
        data_next.status = cip_pkg::ST_OK;
        data_next.dx     = up_pressure - xa;
        data_next.span   = xb - xa;
        data_next.neg    = yb < ya;
        data_next.dmag   = (yb < ya) ? (ya - yb) : (yb - ya);
        if ((up_pressure < cip_pkg::MIN_PRELOAD_LIMIT) ||
            (up_pressure > cip_pkg::MAX_PRELOAD_LIMIT))
        begin
            data_next.base   = '0;
            data_next.status = cip_pkg::ST_INVALID;
        end
        else if (up_pressure <= curve.x[0])
        begin
            data_next.base = curve.y[0];
        end
        else if (up_pressure >= curve.x[3])
        begin
            data_next.base = curve.y[3];
            if ({1'b0, up_pressure} > x3_plus1)
            begin
                data_next.status = cip_pkg::ST_SATURATE;
            end
        end
        else
        begin
            data_next.base   = ya;
            // zero span keeps the left point
            data_next.interp = (xb != xa);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cip_mul.sv -----
`default_nettype none

module cip_mul (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire cip_pkg::lane_t up_data,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output cip_pkg::lane_t      dn_data
);

    logic                        valid_reg;
    cip_pkg::lane_t              data_reg;
    cip_pkg::lane_t              data_next;
    logic [cip_pkg::PROD_W-1:0]  prod;

    assign up_ready = ~valid_reg | dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;
    assign prod     = cip_pkg::PROD_W'(up_data.dx) * cip_pkg::PROD_W'(up_data.dmag);

    // the quotient fits in PRESS_W bits, so the top half starts as the remainder
    always_comb
    begin
        data_next     = up_data;
        data_next.rem = prod[cip_pkg::PROD_W-1:cip_pkg::PRESS_W];
        data_next.num = prod[cip_pkg::PRESS_W-1:0];
        data_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cip_div.sv -----
`default_nettype none

module cip_div (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           up_valid,
    output logic                up_ready,
    input  wire cip_pkg::lane_t up_data,
    output logic                dn_valid,
    input  wire logic           dn_ready,
    output cip_pkg::lane_t      dn_data
);

    localparam int NS = cip_pkg::DIV_STAGES;

    logic [NS-1:0]  valid_reg;
    cip_pkg::lane_t data_reg  [NS];
    cip_pkg::lane_t data_next [NS];
    logic [NS:0]    rdy;

    // one restoring step: shift in a dividend bit, subtract when it fits
    function automatic cip_pkg::lane_t div_step(input cip_pkg::lane_t a);
        cip_pkg::lane_t            b;
        logic [cip_pkg::PRESS_W:0] t;
        b = a;
        t = {a.rem, a.num[cip_pkg::PRESS_W-1]};
        if (t >= {1'b0, a.span})
        begin
            b.rem = cip_pkg::PRESS_W'(t - {1'b0, a.span});
            b.quo = {a.quo[cip_pkg::PRESS_W-2:0], 1'b1};
        end
        else
        begin
            b.rem = t[cip_pkg::PRESS_W-1:0];
            b.quo = {a.quo[cip_pkg::PRESS_W-2:0], 1'b0};
        end
        b.num = {a.num[cip_pkg::PRESS_W-2:0], 1'b0};
        return b;
    endfunction

    always_comb
    begin
        rdy[NS] = dn_ready;
        for (int k = NS - 1; k >= 0; k--)
        begin
            rdy[k] = ~valid_reg[k] | rdy[k+1];
        end
    end

    assign up_ready = rdy[0];
    assign dn_valid = valid_reg[NS-1];
    assign dn_data  = data_reg[NS-1];

    for (genvar k = 0; k < NS; k++)
    begin : g_stage
        logic           src_valid;
        cip_pkg::lane_t src_data;

        if (k == 0)
        begin : g_first
            assign src_valid = up_valid;
            assign src_data  = up_data;
        end
        else
        begin : g_rest
            assign src_valid = valid_reg[k-1];
            assign src_data  = data_reg[k-1];
        end

        always_comb
        begin
            cip_pkg::lane_t t;
            t = src_data;
            for (int j = 0; j < cip_pkg::DIV_BITS_PER_STAGE; j++)
            begin
                t = div_step(t);
            end
            data_next[k] = t;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                valid_reg[k] <= src_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                data_reg[k] <= data_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/cip_out.sv -----
`default_nettype none

module cip_out (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       up_valid,
    output logic                            up_ready,
    input  wire cip_pkg::lane_t             up_data,
    output logic                            dn_valid,
    input  wire logic                       dn_ready,
    output logic [cip_pkg::PRESS_W-1:0]     dn_target,
    output cip_pkg::status_t                dn_status
);

    logic                             valid_reg;
    logic [cip_pkg::PRESS_W-1:0]      target_reg;
    logic [cip_pkg::PRESS_W-1:0]      target_next;
    cip_pkg::status_t                 status_reg;
    logic signed [cip_pkg::SUM_W-1:0] sum;
    logic signed [cip_pkg::SUM_W-1:0] base_s;
    logic signed [cip_pkg::SUM_W-1:0] quo_s;
    logic signed [cip_pkg::SUM_W-1:0] max_s;
    logic signed [cip_pkg::SUM_W-1:0] min_s;

    assign up_ready  = ~valid_reg | dn_ready;
    assign dn_valid  = valid_reg;
    assign dn_target = target_reg;
    assign dn_status = status_reg;

    assign base_s = $signed({2'b00, up_data.base});
    assign quo_s  = $signed({2'b00, up_data.quo});
    assign max_s  = $signed({2'b00, cip_pkg::MAX_AFTERLOAD_LIMIT});
    assign min_s  = $signed({2'b00, cip_pkg::MIN_AFTERLOAD_LIMIT});

    always_comb
    begin
        if (!up_data.interp)
        begin
            sum = base_s;
        end
        else if (up_data.neg)
        begin
            sum = base_s - quo_s;
        end
        else
        begin
            sum = base_s + quo_s;
        end
    end

    // upper limit first, then lower
    always_comb
    begin
        if (up_data.status == cip_pkg::ST_INVALID)
        begin
            target_next = '0;
        end
        else if (sum > max_s)
        begin
            target_next = cip_pkg::MAX_AFTERLOAD_LIMIT;
        end
        else if (sum < min_s)
        begin
            target_next = cip_pkg::MIN_AFTERLOAD_LIMIT;
        end
        else
        begin
            target_next = sum[cip_pkg::PRESS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready)
        begin
            target_reg <= target_next;
            status_reg <= up_data.status;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/curve_interpolator_with_clamp.sv -----
`default_nettype none

// an accepted sample passes through select, multiply, six divider stages at two
//   quotient bits each, and the clamp with its output register to its result word
// throughput: one sample per cycle unless stalled; divider holds one word per stage
// a stalled output backs the pipeline up stage by stage, bubbles still fill
// reset: asynchronous active low, clears all valid bits and loads the default curve

module curve_interpolator_with_clamp (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cip_sample_if.sink                         sample_in,
    cip_result_if.source                       result_out,
    input  wire logic                          cfg_we,
    input  wire logic [cip_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cip_pkg::PRESS_W-1:0]   cfg_data
);

    logic [cip_pkg::PT_COUNT-1:0][cip_pkg::PRESS_W-1:0] curve_x_reg;
    logic [cip_pkg::PT_COUNT-1:0][cip_pkg::PRESS_W-1:0] curve_y_reg;
    cip_pkg::curve_t  curve;

    logic             sel_valid;
    logic             sel_ready;
    cip_pkg::lane_t   sel_data;
    logic             mul_valid;
    logic             mul_ready;
    cip_pkg::lane_t   mul_data;
    logic             div_valid;
    logic             div_ready;
    cip_pkg::lane_t   div_data;
    cip_pkg::status_t out_status;

    assign curve.x = curve_x_reg;
    assign curve.y = curve_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            curve_x_reg <= {cip_pkg::RESET_X3, cip_pkg::RESET_X2,
                            cip_pkg::RESET_X1, cip_pkg::RESET_X0};
            curve_y_reg <= {cip_pkg::RESET_Y3, cip_pkg::RESET_Y2,
                            cip_pkg::RESET_Y1, cip_pkg::RESET_Y0};
        end
        else if (cfg_we)
        begin
            if (cfg_index < cip_pkg::REG_Y_BASE)
            begin
                curve_x_reg[2'(cfg_index - cip_pkg::REG_X_BASE)] <= cfg_data;
            end
            else if (cfg_index < cip_pkg::REG_END)
            begin
                curve_y_reg[2'(cfg_index - cip_pkg::REG_Y_BASE)] <= cfg_data;
            end
        end
    end

    cip_select u_select (
        .clk         (clk),
        .rst_n       (rst_n),
        .curve       (curve),
        .up_valid    (sample_in.valid),
        .up_ready    (sample_in.ready),
        .up_pressure (sample_in.inlet_pressure),
        .dn_valid    (sel_valid),
        .dn_ready    (sel_ready),
        .dn_data     (sel_data)
    );

    cip_mul u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (sel_valid),
        .up_ready (sel_ready),
        .up_data  (sel_data),
        .dn_valid (mul_valid),
        .dn_ready (mul_ready),
        .dn_data  (mul_data)
    );

    cip_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (mul_valid),
        .up_ready (mul_ready),
        .up_data  (mul_data),
        .dn_valid (div_valid),
        .dn_ready (div_ready),
        .dn_data  (div_data)
    );

    cip_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (div_valid),
        .up_ready  (div_ready),
        .up_data   (div_data),
        .dn_valid  (result_out.valid),
        .dn_ready  (result_out.ready),
        .dn_target (result_out.target_pressure),
        .dn_status (out_status)
    );

    assign result_out.status = out_status;

`ifndef SYNTHESIS
    // an invalid sample always gives a zero target
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && (result_out.status == cip_pkg::ST_INVALID)
        |-> result_out.target_pressure == '0)
        else $error("invalid preload word with nonzero target");

    // every other word lies inside the afterload window
    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid && (result_out.status != cip_pkg::ST_INVALID)
        |-> (result_out.target_pressure <= cip_pkg::MAX_AFTERLOAD_LIMIT) ||
            (result_out.target_pressure == cip_pkg::MIN_AFTERLOAD_LIMIT))
        else $error("target outside afterload window");

    // input backpressure only when the whole pipeline is full and the output stalls
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_in.ready |-> result_out.valid && !result_out.ready)
        else $error("input stalled without output backpressure");

    // status code never leaves its defined set
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.status == cip_pkg::ST_OK) ||
                             (result_out.status == cip_pkg::ST_INVALID) ||
                             (result_out.status == cip_pkg::ST_SATURATE))
        else $error("undefined status code");
`endif

endmodule

`default_nettype wire
